FILE: rtl/obd_pid_reply_decoder_defines.svh
// Assertion macros used by the parser and top-level reply decoder RTL files.
`ifndef OBD_PID_REPLY_DECODER_DEFINES_SVH
`define OBD_PID_REPLY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define OBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("obd_prd: property violated");
// Condition that must never be seen outside reset
`define OBD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("obd_prd: forbidden condition seen");
`else
`define OBD_ASSERT(label, clk, rst, prop)
`define OBD_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: rtl/obd_prd_pkg.sv
// Shared constants, codes and types of the PID reply decoder.
`default_nettype none
package obd_prd_pkg;

   // Sizing
   localparam int LINE_BYTES = 24;
   localparam int MAX_DATA   = 8;
   localparam int LBC_W      = $clog2(LINE_BYTES + 1);
   localparam int MC_W       = $clog2(MAX_DATA + 1);
   localparam int VAL_W      = 23;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_MATCH  = 2'd1;
   localparam logic [1:0] ST_TOO_SHORT = 2'd2;
   localparam logic [1:0] ST_NO_FORMULA = 2'd3;

   // Positive reply header for mode 01
   localparam logic [7:0] RSP_MODE01 = 8'h41;

   // PIDs with a known formula
   localparam logic [7:0] PID_LOAD     = 8'h04;
   localparam logic [7:0] PID_COOLANT  = 8'h05;
   localparam logic [7:0] PID_RPM      = 8'h0C;
   localparam logic [7:0] PID_SPEED    = 8'h0D;
   localparam logic [7:0] PID_IAT      = 8'h0F;
   localparam logic [7:0] PID_MAF      = 8'h10;
   localparam logic [7:0] PID_THROTTLE = 8'h11;
   localparam logic [7:0] PID_FUEL     = 8'h2F;
   localparam logic [7:0] PID_VOLTAGE  = 8'h42;
   localparam logic [7:0] PID_AMBIENT  = 8'h46;
   localparam logic [7:0] PID_OIL      = 8'h5C;

   // Match summary handed from the line parser to the scaler
   typedef struct packed {
      logic       found;
      logic [3:0] count;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] pid;
   } match_type;

endpackage
`default_nettype wire

FILE: rtl/obd_prd_parse.sv
// Character parser: hex pairing, line framing and header match.
`default_nettype none
`include "obd_pid_reply_decoder_defines.svh"
module obd_prd_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             reply_char,
   input  wire logic [7:0]             wanted_pid,
   input  wire logic                   end_of_reply,
   output obd_prd_pkg::match_type      fin_data
);
   import obd_prd_pkg::*;

   localparam logic [7:0] CH_BAR = 8'h7C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   // Line state
   logic [3:0]       hn_ff, hn_in;
   logic             np_ff, np_in;
   logic [LBC_W-1:0] lbc_ff, lbc_in;
   logic [7:0]       hdr_ff [2];
   logic [7:0]       hdr_in [2];
   logic [7:0]       dat_ff [2];
   logic [7:0]       dat_in [2];
   // Held match
   logic             mf_ff, mf_in;
   logic [MC_W-1:0]  mc_ff, mc_in;
   logic [7:0]       mb_ff [2];
   logic [7:0]       mb_in [2];

   logic             is_term;
   logic             is_dig;
   logic [3:0]       dig_val;
   logic [7:0]       byte_v;
   logic [LBC_W-1:0] n_bytes;

   // Hex digit decode
   always_comb begin
      is_dig  = 1'b1;
      dig_val = 4'd0;
      if (reply_char inside {[8'h30:8'h39]}) begin
         dig_val = reply_char[3:0];
      end else if (reply_char inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         dig_val = reply_char[3:0] + 4'd9;
      end else begin
         is_dig = 1'b0;
      end
   end

   assign is_term = (reply_char == CH_BAR) || (reply_char == CH_CR) || (reply_char == CH_LF);
   assign byte_v  = {hn_ff, dig_val};

   // One character: digit or terminator, then a closing pass on the final beat
   always_comb begin
      hn_in   = hn_ff;
      np_in   = np_ff;
      lbc_in  = lbc_ff;
      hdr_in  = hdr_ff;
      dat_in  = dat_ff;
      mf_in   = mf_ff;
      mc_in   = mc_ff;
      mb_in   = mb_ff;
      n_bytes = '0;
      fin_data = '0;
      if (step) begin
         // pack digits, ignoring those past a full line
         if (!is_term && is_dig && int'(lbc_ff) < LINE_BYTES) begin
            if (!np_ff) begin
               hn_in = dig_val;
               np_in = 1'b1;
            end else begin
               np_in = 1'b0;
               if (int'(lbc_ff) < 2) begin
                  hdr_in[lbc_ff[0]] = byte_v;
               end else if (int'(lbc_ff) < 4) begin
                  dat_in[lbc_ff[0]] = byte_v;
               end
               lbc_in = lbc_ff + 1'b1;
            end
         end
         // close the line; first matching line wins
         if (is_term || end_of_reply) begin
            if (!mf_in && int'(lbc_in) >= 3 && hdr_in[0] == RSP_MODE01 &&
                hdr_in[1] == wanted_pid) begin
               n_bytes  = lbc_in - LBC_W'(2);
               mf_in    = 1'b1;
               mc_in    = (int'(n_bytes) < MAX_DATA) ? MC_W'(n_bytes) : MC_W'(MAX_DATA);
               mb_in[0] = dat_in[0];
               mb_in[1] = (int'(n_bytes) >= 2) ? dat_in[1] : 8'd0;
            end
            lbc_in = '0;
            np_in  = 1'b0;
            hn_in  = '0;
            hdr_in = '{default: 8'd0};
            dat_in = '{default: 8'd0};
         end
         // summary of the reply, meaningful on the final beat
         fin_data.found  = mf_in;
         fin_data.count  = (int'(mc_in) > 15) ? 4'd15 : 4'(mc_in);
         fin_data.byte_a = mb_in[0];
         fin_data.byte_b = mb_in[1];
         fin_data.pid    = wanted_pid;
         // a new reply starts from scratch
         if (end_of_reply) begin
            mf_in = 1'b0;
            mc_in = '0;
            mb_in = '{default: 8'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hn_ff  <= '0;
         np_ff  <= 1'b0;
         lbc_ff <= '0;
         hdr_ff <= '{default: 8'd0};
         dat_ff <= '{default: 8'd0};
         mf_ff  <= 1'b0;
         mc_ff  <= '0;
         mb_ff  <= '{default: 8'd0};
      end else begin
         hn_ff  <= hn_in;
         np_ff  <= np_in;
         lbc_ff <= lbc_in;
         hdr_ff <= hdr_in;
         dat_ff <= dat_in;
         mf_ff  <= mf_in;
         mc_ff  <= mc_in;
         mb_ff  <= mb_in;
      end
   end

   `OBD_ASSERT_NEVER(a_line_overfill, clock, reset, int'(lbc_ff) > LINE_BYTES)
   `OBD_ASSERT_NEVER(a_count_over_cap, clock, reset, int'(mc_ff) > MAX_DATA)
   `OBD_ASSERT(a_clear_after_last, clock, reset, step && end_of_reply |=> !mf_ff && lbc_ff == '0)

endmodule
`default_nettype wire

FILE: rtl/obd_prd_scale.sv
// PID formula scaling, status selection and the result register.
`default_nettype none
module obd_prd_scale (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fin_valid,
   input  wire obd_prd_pkg::match_type fin_data,
   output logic                        fin_take,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic signed [obd_prd_pkg::VAL_W-1:0] rsp_value_q8,
   output logic [3:0]                  rsp_data_count,
   output logic [7:0]                  rsp_first_byte,
   output logic [7:0]                  rsp_second_byte
);
   import obd_prd_pkg::*;

   // Reciprocals: A*100/255 fraction, AB*64/25, AB*32/125
   localparam logic [22:0] PCT_RECIP  = 23'd6579400;
   localparam logic [22:0] MAF_RECIP  = 23'd5368710;
   localparam logic [21:0] VOLT_RECIP = 22'd2147484;

   logic              valid_ff;
   logic [1:0]        status_ff, status_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [3:0]        count_ff, count_in;
   logic [7:0]        a_ff, a_in;
   logic [7:0]        b_ff, b_in;

   logic [15:0]       ab;
   logic [30:0]       pct_prod;
   logic [38:0]       maf_prod;
   logic [37:0]       volt_prod;
   logic signed [8:0] temp_c;
   logic              two_byte;
   logic              known;
   logic [VAL_W-1:0]  formula;

   assign fin_take = fin_valid && (!valid_ff || rsp_ready);

   // Constant scaling, all three products side by side
   assign ab        = {fin_data.byte_a, fin_data.byte_b};
   assign pct_prod  = 31'(fin_data.byte_a) * 31'(PCT_RECIP);
   assign maf_prod  = 39'(ab) * 39'(MAF_RECIP);
   assign volt_prod = 38'(ab) * 38'(VOLT_RECIP);
   assign temp_c    = $signed({1'b0, fin_data.byte_a}) - 9'sd40;

   always_comb begin
      two_byte = 1'b0;
      known    = 1'b1;
      formula  = '0;
      case (fin_data.pid)
         PID_LOAD, PID_THROTTLE, PID_FUEL: begin
            formula = VAL_W'(fin_data.byte_a) * VAL_W'(100) + VAL_W'(pct_prod[30:24]);
         end
         PID_COOLANT, PID_IAT, PID_AMBIENT, PID_OIL: begin
            formula = {{(VAL_W - 17){temp_c[8]}}, temp_c, 8'd0};
         end
         PID_SPEED: begin
            formula = VAL_W'({fin_data.byte_a, 8'd0});
         end
         PID_RPM: begin
            two_byte = 1'b1;
            formula  = VAL_W'({ab, 6'd0});
         end
         PID_MAF: begin
            two_byte = 1'b1;
            formula  = VAL_W'(maf_prod[38:21]);
         end
         PID_VOLTAGE: begin
            two_byte = 1'b1;
            formula  = VAL_W'(volt_prod[37:23]);
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Status and field masking
   always_comb begin
      status_in = ST_OK;
      value_in  = formula;
      count_in  = fin_data.count;
      a_in      = fin_data.byte_a;
      b_in      = fin_data.byte_b;
      if (!fin_data.found) begin
         status_in = ST_NO_MATCH;
         value_in  = '0;
         count_in  = '0;
         a_in      = '0;
         b_in      = '0;
      end else if (!known) begin
         status_in = ST_NO_FORMULA;
         value_in  = '0;
      end else if (two_byte && fin_data.count < 4'd2) begin
         status_in = ST_TOO_SHORT;
         value_in  = '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (fin_take) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         count_ff  <= count_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_value_q8    = $signed(value_ff);
   assign rsp_data_count  = count_ff;
   assign rsp_first_byte  = a_ff;
   assign rsp_second_byte = b_ff;

endmodule
`default_nettype wire

FILE: rtl/obd_pid_reply_decoder.sv
// On the final character the summary stage loads, then the result register takes it.
// Throughput: one character per cycle, but a final character stalls while the summary
// stage is full and not taken; the result register and the summary stage keep other
// characters flowing while a result waits. The per-character state update is a loop.
// Reset: synchronous, active high; clears handshake and parser state, not data registers.
// Top level of the mode 01 PID reply decoder.
`default_nettype none
`include "obd_pid_reply_decoder_defines.svh"
module obd_pid_reply_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_reply_char,
   input  wire logic [7:0]  req_wanted_pid,
   input  wire logic        req_end_of_reply,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic signed [obd_prd_pkg::VAL_W-1:0] rsp_value_q8,
   output logic [3:0]       rsp_data_count,
   output logic [7:0]       rsp_first_byte,
   output logic [7:0]       rsp_second_byte
);
   import obd_prd_pkg::*;

   // Input register
   logic       in_v_ff;
   logic [7:0] char_ff;
   logic [7:0] pid_ff;
   logic       last_ff;
   logic       in_go;

   // Summary stage between parser and scaler
   logic       fin_v_ff;
   match_type  fin_ff;
   match_type  fin_in;
   logic       fin_take;
   logic       fin_free;

   assign fin_free  = !fin_v_ff || fin_take;
   assign in_go     = in_v_ff && (!last_ff || fin_free);
   assign req_ready = !in_v_ff || in_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_ready) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         char_ff <= req_reply_char;
         pid_ff  <= req_wanted_pid;
         last_ff <= req_end_of_reply;
      end
   end

   obd_prd_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (in_go),
      .reply_char   (char_ff),
      .wanted_pid   (pid_ff),
      .end_of_reply (last_ff),
      .fin_data     (fin_in)
   );

   // Summary beat, loaded on the final character
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (in_go && last_ff) begin
         fin_v_ff <= 1'b1;
      end else if (fin_take) begin
         fin_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_go && last_ff) begin
         fin_ff <= fin_in;
      end
   end

   obd_prd_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .fin_valid       (fin_v_ff),
      .fin_data        (fin_ff),
      .fin_take        (fin_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_value_q8    (rsp_value_q8),
      .rsp_data_count  (rsp_data_count),
      .rsp_first_byte  (rsp_first_byte),
      .rsp_second_byte (rsp_second_byte)
   );

   `OBD_ASSERT(a_fin_held, clock, reset, fin_v_ff && !fin_take |=> fin_v_ff && $stable(fin_ff))
   `OBD_ASSERT(a_no_match_zero, clock, reset, rsp_valid && rsp_status == ST_NO_MATCH |-> rsp_value_q8 == '0 && rsp_data_count == '0 && rsp_first_byte == '0 && rsp_second_byte == '0)
   `OBD_ASSERT(a_error_no_value, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_value_q8 == '0)

endmodule
`default_nettype wire
